[hdl/bct_pkg.sv]
package bct_pkg;

	// Coordinate and fixed point widths
	localparam int CoordW = 16;           // input coordinate width
	localparam int OutW   = 16;           // output coordinate width
	localparam int FracW  = 16;           // Q16 fraction bits
	localparam int QW     = CoordW + FracW; // Q16 coordinate width
	localparam int TW     = FracW + 1;    // t in [0, 1.0], Q16
	localparam int SegW   = 6;            // segment count width
	localparam int PW     = QW + TW + 2;  // lerp product width
	localparam int CntW   = $clog2(TW);   // divider bit counter

	localparam logic [SegW-1:0] MaxSegments   = SegW'(63);
	localparam int              QueueDepthDef = 2;

	// Degree opcodes
	localparam logic OpQuad  = 1'b0;
	localparam logic OpCubic = 1'b1;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [OutW-1:0]   point_t;
	typedef logic        [SegW-1:0]   seg_t;
	typedef logic        [TW-1:0]     tq_t;
	typedef logic signed [QW-1:0]     q_t;
	typedef logic signed [PW-1:0]     prod_t;

	// One curve as it travels from the front to the back
	typedef struct packed {
		logic              cubic;
		coord_t [3:0]      px;
		coord_t [3:0]      py;
		seg_t              nseg;    // saturated segment count
		tq_t               step_q;  // floor(1.0 / nseg) in Q16
		logic [SegW-1:0]   step_r;  // remainder of that division
	} curve_t;

	function automatic q_t to_q16(coord_t c);
		return q_t'({c, {FracW{1'b0}}});
	endfunction

	// (b - a) * t, kept at full width
	function automatic prod_t lerp_mul(q_t a, q_t b, tq_t t);
		logic signed [QW:0] d;
		logic signed [TW:0] ts;
		d  = {b[QW-1], b} - {a[QW-1], a};
		ts = {1'b0, t};
		return prod_t'(d) * prod_t'(ts);
	endfunction

	// a + (product rounded half up to Q16); wraps safely, result is in range
	function automatic q_t lerp_fin(q_t a, prod_t p);
		prod_t s;
		s = p + (prod_t'(1) <<< (FracW - 1));
		return a + q_t'(s >>> FracW);
	endfunction

	// Nearest integer, half up, low OutW bits
	function automatic point_t round_out(q_t v);
		logic signed [QW:0] s;
		s = {v[QW-1], v} + ((QW+1)'(1) << (FracW - 1));
		return point_t'(s >>> FracW);
	endfunction

endpackage

[hdl/bezier_curve_tessellator.sv]
// Quadratic / cubic Bezier tessellator, de Casteljau in Q16 fixed point.
// Input channel (in_valid / in_stall): one item per curve - opcode (0 quad,
// 1 cubic), control points p0..p3 and segment_count n (above 63 saturates).
// Output channel (out_valid / out_stall): n+1 items per curve, point_x/y at
// t = i/n for i = 0..n, rounded to integers; last marks the final point.
// n = 0 gives the start point alone, with last set.
// Front: takes a curve and works out the Q16 step 1/n with a bit-serial
// divider, one quotient bit a cycle; a curve occupies it for 17 divide steps
// and a hand-over that waits while the queue is full; in_stall is high meanwhile.
// Queue: QUEUE_DEPTH curves between front and back.
// Back: steps t exactly by quotient and remainder, one point a cycle unless
// out_stall holds it, into a four-stage interpolation pipeline (three lerp
// levels, rounding). Front, queue and back run concurrently, so the front
// can take a new curve while the back still emits points of an earlier one.
// out_stall freezes the whole back pipeline; the queue then fills and the
// front raises in_stall. Nothing is dropped.
// Reset (arst_n low) empties queue and pipeline; no clearing pass needed.
module bezier_curve_tessellator #(
	parameter int QUEUE_DEPTH = bct_pkg::QueueDepthDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             opcode,
	input  bct_pkg::coord_t  p0_x,
	input  bct_pkg::coord_t  p0_y,
	input  bct_pkg::coord_t  p1_x,
	input  bct_pkg::coord_t  p1_y,
	input  bct_pkg::coord_t  p2_x,
	input  bct_pkg::coord_t  p2_y,
	input  bct_pkg::coord_t  p3_x,
	input  bct_pkg::coord_t  p3_y,
	input  bct_pkg::seg_t    segment_count,
	output logic             out_valid,
	input  logic             out_stall,
	output bct_pkg::point_t  point_x,
	output bct_pkg::point_t  point_y,
	output logic             last
);
	import bct_pkg::*;

	curve_t in_item;
	curve_t q_item;
	curve_t head;
	logic   q_push, q_full, q_pop, q_valid;

	// pack the incoming item; step fields are filled by the front
	always_comb begin
		in_item        = '0;
		in_item.cubic  = (opcode == OpCubic);
		in_item.px     = {p3_x, p2_x, p1_x, p0_x};
		in_item.py     = {p3_y, p2_y, p1_y, p0_y};
		in_item.nseg   = segment_count;
	end

	bct_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_push   (q_push),
		.q_item   (q_item),
		.q_full   (q_full)
	);

	bct_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_item),
		.full       (q_full),
		.pop        (q_pop),
		.head       (head),
		.head_valid (q_valid)
	);

	bct_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.head      (head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.point_x   (point_x),
		.point_y   (point_y),
		.last      (last)
	);

	// no push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("curve pushed into full queue");

	// pops only from a non-empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("curve popped from empty queue");

	// front goes busy right after taking a curve
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("front accepted a curve without going busy");

endmodule

[hdl/bct_front.sv]
module bct_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  bct_pkg::curve_t in_item,
	output logic            q_push,
	output bct_pkg::curve_t q_item,
	input  logic            q_full
);
	import bct_pkg::*;

	typedef enum logic [1:0] {IDLE, DIVIDE, PUSH} state_t;

	state_t          state_q;
	curve_t          item_q;
	logic [CntW-1:0] cnt_q;
	logic [SegW-1:0] rem_q;
	tq_t             quo_q;

	logic            accept;
	logic [SegW:0]   shifted;
	logic            ge;
	seg_t            nsat;
	curve_t          in_sat;

	assign in_stall = (state_q != IDLE);
	assign accept   = in_valid && !in_stall;
	assign q_push   = (state_q == PUSH) && !q_full;
	assign q_item   = item_q;

	assign nsat = (in_item.nseg > MaxSegments) ? MaxSegments : in_item.nseg;

	// incoming curve with its segment count clamped
	always_comb begin
		in_sat      = in_item;
		in_sat.nseg = nsat;
	end

	// restoring divide of 1.0 (only the top dividend bit set) by nseg
	assign shifted = {rem_q, (cnt_q == CntW'(TW - 1))};
	assign ge      = (shifted >= {1'b0, item_q.nseg});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			item_q  <= '0;
			cnt_q   <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						item_q      <= in_sat;
						cnt_q       <= CntW'(TW - 1);
						rem_q       <= '0;
						quo_q       <= '0;
						state_q     <= DIVIDE;
					end
				end
				DIVIDE: begin
					rem_q <= ge ? SegW'(shifted - {1'b0, item_q.nseg}) : shifted[SegW-1:0];
					quo_q <= {quo_q[TW-2:0], ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						item_q.step_q <= {quo_q[TW-2:0], ge};
						item_q.step_r <= ge ? SegW'(shifted - {1'b0, item_q.nseg})
						                    : shifted[SegW-1:0];
						state_q       <= PUSH;
					end
				end
				PUSH: begin
					if (!q_full)
						state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

[hdl/bct_queue.sv]
module bct_queue #(
	parameter int DEPTH = bct_pkg::QueueDepthDef
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bct_pkg::curve_t push_item,
	output logic            full,
	input  logic            pop,
	output bct_pkg::curve_t head,
	output logic            head_valid
);
	import bct_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NumW = $clog2(DEPTH + 1);

	curve_t          mem_q [DEPTH];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [NumW-1:0] num_q;

	function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
		return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (num_q == NumW'(DEPTH));
	assign head_valid = (num_q != '0);
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			num_q <= '0;
		end else begin
			if (push)
				wr_q <= ptr_inc(wr_q);
			if (pop)
				rd_q <= ptr_inc(rd_q);
			if (push && !pop)
				num_q <= num_q + 1'b1;
			else if (pop && !push)
				num_q <= num_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

endmodule

[hdl/bct_back.sv]
module bct_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  bct_pkg::curve_t  head,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output bct_pkg::point_t  point_x,
	output bct_pkg::point_t  point_y,
	output logic             last
);
	import bct_pkg::*;

	// sequencer
	curve_t          cur_q;
	logic            busy_q;
	seg_t            idx_q;
	tq_t             t_q;
	logic [SegW-1:0] rem_q;

	logic            adv, issue, is_last, wrap;
	logic [SegW:0]   rsum;
	logic [SegW-1:0] rem_nxt;
	tq_t             t_nxt;

	assign adv     = !out_valid || !out_stall;
	assign issue   = busy_q && adv;
	assign is_last = (idx_q == cur_q.nseg);
	assign q_pop   = q_valid && (!busy_q || (issue && is_last));

	// t(i+1) = t(i) + 1/n with the remainder carried exactly
	assign rsum    = {1'b0, rem_q} + {1'b0, cur_q.step_r};
	assign wrap    = (rsum >= {1'b0, cur_q.nseg});
	assign rem_nxt = wrap ? SegW'(rsum - {1'b0, cur_q.nseg}) : rsum[SegW-1:0];
	assign t_nxt   = t_q + cur_q.step_q + TW'(wrap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			if (q_pop)
				busy_q <= 1'b1;
			else if (issue && is_last)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= head;
			idx_q <= '0;
			t_q   <= '0;
			rem_q <= head.nseg >> 1;
		end else if (issue) begin
			idx_q <= idx_q + 1'b1;
			t_q   <= t_nxt;
			rem_q <= rem_nxt;
		end
	end

	// evaluation pipeline: one de Casteljau level per stage, then rounding; axis 0 = x, 1 = y
	q_t    qv     [2][4];
	q_t    l1     [2][3];
	q_t    l2     [2][2];
	q_t    fin    [2];

	q_t    a1_s1  [2][3];
	prod_t p1_s1  [2][3];
	q_t    a2_s2  [2][2];
	prod_t p2_s2  [2][2];
	q_t    a3_s3  [2];
	prod_t p3_s3  [2];
	tq_t   t_s1, t_s2;
	logic  last_s1, last_s2, last_s3, last_s4;
	logic  cub_s1, cub_s2, cub_s3;
	logic  vld_s1, vld_s2, vld_s3, vld_s4;
	point_t px_s4, py_s4;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			qv[0][k] = to_q16(cur_q.px[k]);
			qv[1][k] = to_q16(cur_q.py[k]);
		end
		for (int ax = 0; ax < 2; ax++) begin
			for (int k = 0; k < 3; k++)
				l1[ax][k] = lerp_fin(a1_s1[ax][k], p1_s1[ax][k]);
			for (int k = 0; k < 2; k++)
				l2[ax][k] = lerp_fin(a2_s2[ax][k], p2_s2[ax][k]);
			// quadratic result is the first level-two point
			fin[ax] = cub_s3 ? lerp_fin(a3_s3[ax], p3_s3[ax]) : a3_s3[ax];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int ax = 0; ax < 2; ax++) begin
				for (int k = 0; k < 3; k++) begin
					a1_s1[ax][k] <= qv[ax][k];
					p1_s1[ax][k] <= lerp_mul(qv[ax][k], qv[ax][k+1], t_q);
				end
				for (int k = 0; k < 2; k++) begin
					a2_s2[ax][k] <= l1[ax][k];
					p2_s2[ax][k] <= lerp_mul(l1[ax][k], l1[ax][k+1], t_s1);
				end
				a3_s3[ax] <= l2[ax][0];
				p3_s3[ax] <= lerp_mul(l2[ax][0], l2[ax][1], t_s2);
			end
			px_s4   <= round_out(fin[0]);
			py_s4   <= round_out(fin[1]);
			t_s1    <= t_q;
			t_s2    <= t_s1;
			last_s1 <= is_last;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
			last_s4 <= last_s3;
			cub_s1  <= cur_q.cubic;
			cub_s2  <= cub_s1;
			cub_s3  <= cub_s2;
		end
	end

	assign out_valid = vld_s4;
	assign point_x   = px_s4;
	assign point_y   = py_s4;
	assign last      = last_s4;

endmodule
